// ----- rtl/plucked_string_synth_core_macros.svh -----
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef PLUCKED_STRING_SYNTH_CORE_MACROS_SVH
`define PLUCKED_STRING_SYNTH_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/psynth_pkg.sv -----
`timescale 1ns / 1ps

package psynth_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_BITS      = 16;
    localparam int LEN_BITS       = 12;
    localparam int CMD_BITS       = 2;
    localparam int GAIN_SHIFT     = 17;
    localparam int MIN_LEN        = 2;
    localparam int DEF_MAX_DELAY  = 2048;
    localparam int LEN_RESET      = 100;
    localparam int GAIN_RESET     = 65208;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELAY_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOP_GAIN    = 2'd1;

    localparam logic KIND_AUDIO = 1'b0;
    localparam logic KIND_PEAK  = 1'b1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_START = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_PEAK  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] peak_level;
        logic [SAMPLE_BITS-1:0] audio_out;
        logic                   result_kind;
    } result_t;

endpackage

// ----- rtl/plucked_string_synth_core.sv -----
`timescale 1ns / 1ps

// Plucked string synthesizer: a Karplus-Strong delay line of delay_length Q1.15 samples
// held in a synchronous memory with one read and one write port. Commands arrive on
// s_tuser: start rewinds the load position, load writes the next excitation sample, tick
// returns the oldest sample and feeds back loop_gain * (oldest + next) / 2 rounded down,
// and a peak query returns the largest magnitude in the line. A tick makes its two
// dependent reads, the registered multiply and the write back of the new sample; a peak
// query makes one memory read per sample. Results leave through an output register, so
// new commands are taken while a result waits; a second result stalls the block until
// the output is free. After reset the block runs a clearing pass over all MAX_DELAY
// entries (2048 by default) that zeroes the line, and accepts no command until it
// finishes; configuration writes are taken at any time but are meant for an idle block.
module plucked_string_synth_core
    import psynth_pkg::*;
#(
    parameter int MAX_DELAY = DEF_MAX_DELAY
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [SAMPLE_BITS-1:0]    s_tdata,   // sample_in
    input  logic [CMD_BITS-1:0]       s_tuser,   // command
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [2*SAMPLE_BITS-1:0]  m_tdata,   // peak_level (upper half), audio_out (lower half)
    output logic                      m_tuser,   // result_kind
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int LW = $clog2(MAX_DELAY + 1);

    logic [LEN_BITS-1:0]    delay_len_reg, delay_len_next;
    logic [GAIN_BITS-1:0]   gain_reg, gain_next;
    logic                   cfg_accept;
    logic                   len_wr;
    logic [LW-1:0]          line_len;
    logic                   line_ready;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [SAMPLE_BITS-1:0] wr_data;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    always_comb
    begin
        delay_len_next = delay_len_reg;
        gain_next      = gain_reg;
        len_wr         = 1'b0;
        if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_DELAY_LENGTH:
                begin
                    delay_len_next = cfg_data[LEN_BITS-1:0];
                    len_wr         = 1'b1;
                end
                CFG_LOOP_GAIN:
                begin
                    gain_next = cfg_data[GAIN_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_len_reg <= LEN_BITS'(LEN_RESET);
            gain_reg      <= GAIN_BITS'(GAIN_RESET);
        end
        else
        begin
            delay_len_reg <= delay_len_next;
            gain_reg      <= gain_next;
        end
    end

    // The programmed length is saturated to the range the line supports.
    always_comb
    begin
        if (32'(delay_len_reg) < MIN_LEN)
        begin
            line_len = LW'(MIN_LEN);
        end
        else if (32'(delay_len_reg) > MAX_DELAY)
        begin
            line_len = LW'(MAX_DELAY);
        end
        else
        begin
            line_len = LW'(delay_len_reg);
        end
    end

    psynth_line #(
        .MAX_DELAY (MAX_DELAY)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .ready   (line_ready)
    );

    psynth_ctrl #(
        .MAX_DELAY (MAX_DELAY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_len   (line_len),
        .loop_gain  (gain_reg),
        .len_wr     (len_wr),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .line_ready (line_ready),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

endmodule

// ----- rtl/psynth_line.sv -----
`timescale 1ns / 1ps
`include "plucked_string_synth_core_macros.svh"

module psynth_line
    import psynth_pkg::*;
#(
    parameter int MAX_DELAY = DEF_MAX_DELAY
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [$clog2(MAX_DELAY)-1:0] rd_addr,
    output logic [SAMPLE_BITS-1:0]      rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(MAX_DELAY)-1:0] wr_addr,
    input  logic [SAMPLE_BITS-1:0]      wr_data,
    output logic                        ready
);

    localparam int AW = $clog2(MAX_DELAY);

    logic [SAMPLE_BITS-1:0] mem [MAX_DELAY];
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   clr_busy_reg;
    logic                   clr_busy_next;
    logic [AW-1:0]          clr_addr_reg;
    logic [AW-1:0]          clr_addr_next;
    logic                   mem_we;
    logic [AW-1:0]          mem_wa;
    logic [SAMPLE_BITS-1:0] mem_wd;

    // After reset every entry is swept to zero before the line is used.
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(MAX_DELAY - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign mem_we = clr_busy_reg | wr_en;
    assign mem_wa = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign mem_wd = clr_busy_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clr_busy_reg;

    `PSS_ASSERT_NOW(a_no_write_in_clear, clr_busy_reg, !wr_en, "write during clearing pass")
    `PSS_ASSERT_NOW(a_no_read_in_clear, clr_busy_reg, !rd_en, "read during clearing pass")
    `PSS_ASSERT_NEXT(a_clear_once, !clr_busy_reg, !clr_busy_reg, "clearing pass restarted")

endmodule

// ----- rtl/psynth_ctrl.sv -----
`timescale 1ns / 1ps
`include "plucked_string_synth_core_macros.svh"

module psynth_ctrl
    import psynth_pkg::*;
#(
    parameter int MAX_DELAY = DEF_MAX_DELAY
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(MAX_DELAY+1)-1:0] line_len,
    input  logic [GAIN_BITS-1:0]           loop_gain,
    input  logic                           len_wr,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [SAMPLE_BITS-1:0]         s_tdata,
    input  logic [CMD_BITS-1:0]            s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [2*SAMPLE_BITS-1:0]       m_tdata,
    output logic                           m_tuser,
    input  logic                           line_ready,
    output logic                           rd_en,
    output logic [$clog2(MAX_DELAY)-1:0]   rd_addr,
    input  logic [SAMPLE_BITS-1:0]         rd_data,
    output logic                           wr_en,
    output logic [$clog2(MAX_DELAY)-1:0]   wr_addr,
    output logic [SAMPLE_BITS-1:0]         wr_data
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int LW = $clog2(MAX_DELAY + 1);
    localparam int PW = SAMPLE_BITS + GAIN_BITS + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_Y0,
        ST_TICK_Y1,
        ST_TICK_WR,
        ST_PEAK_SCAN,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [LW-1:0]           load_reg, load_next;
    logic [LW-1:0]           cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0]  y0_reg, y0_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic [SAMPLE_BITS-1:0]  peak_reg, peak_next;
    result_t                 pend_reg, pend_next;
    result_t                 out_reg, out_next;
    logic                    m_valid_reg, m_valid_next;

    logic                    in_accept;
    logic                    out_free;
    logic                    emit;
    result_t                 res;
    logic [LW-1:0]           head_inc;
    logic [AW-1:0]           head_adv;
    logic [LW:0]             load_sum;
    logic [AW-1:0]           load_slot;
    logic signed [SAMPLE_BITS:0] pair_sum;
    logic [SAMPLE_BITS-1:0]  mag;
    logic [SAMPLE_BITS-1:0]  peak_new;

    assign s_tready  = (state_reg == ST_IDLE) && line_ready;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // Slot after the head, wrapping at the line length.
    assign head_inc = LW'(head_reg) + LW'(1);
    assign head_adv = (head_inc == line_len) ? '0 : AW'(head_inc);

    // Load position is an offset from the head; the sum stays below twice the length.
    assign load_sum  = (LW+1)'(head_reg) + (LW+1)'(load_reg);
    assign load_slot = (load_sum >= (LW+1)'(line_len)) ?
                       AW'(load_sum - (LW+1)'(line_len)) : AW'(load_sum);

    assign pair_sum = $signed({y0_reg[SAMPLE_BITS-1], y0_reg}) +
                      $signed({rd_data[SAMPLE_BITS-1], rd_data});

    // The two's complement of the most negative sample reads correctly as unsigned.
    assign mag      = rd_data[SAMPLE_BITS-1] ? (~rd_data + SAMPLE_BITS'(1)) : rd_data;
    assign peak_new = (mag > peak_reg) ? mag : peak_reg;

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        load_next    = load_reg;
        cnt_next     = cnt_reg;
        y0_next      = y0_reg;
        prod_next    = prod_reg;
        peak_next    = peak_reg;
        pend_next    = pend_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        emit         = 1'b0;
        res          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (cmd_t'(s_tuser))
                        CMD_START:
                        begin
                            load_next = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (load_reg < line_len)
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = load_slot;
                                wr_data   = s_tdata;
                                load_next = load_reg + LW'(1);
                            end
                        end
                        CMD_TICK:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = ST_TICK_Y0;
                        end
                        CMD_PEAK:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            cnt_next   = LW'(1);
                            peak_next  = '0;
                            state_next = ST_PEAK_SCAN;
                        end
                    endcase
                end
            end
            ST_TICK_Y0:
            begin
                y0_next    = rd_data;
                rd_en      = 1'b1;
                rd_addr    = head_adv;
                state_next = ST_TICK_Y1;
            end
            ST_TICK_Y1:
            begin
                prod_next  = PW'(pair_sum) * $signed({2'b00, loop_gain});
                state_next = ST_TICK_WR;
            end
            ST_TICK_WR:
            begin
                // Arithmetic shift of the product rounds toward minus infinity.
                wr_en           = 1'b1;
                wr_addr         = head_reg;
                wr_data         = prod_reg[GAIN_SHIFT +: SAMPLE_BITS];
                head_next       = head_adv;
                res.result_kind = KIND_AUDIO;
                res.audio_out   = y0_reg;
                emit            = 1'b1;
            end
            ST_PEAK_SCAN:
            begin
                peak_next = peak_new;
                if (cnt_reg == line_len)
                begin
                    res.result_kind = KIND_PEAK;
                    res.peak_level  = peak_new;
                    emit            = 1'b1;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(cnt_reg);
                    cnt_next = cnt_reg + LW'(1);
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    out_next     = pend_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished result goes straight out if the output word is free.
        if (emit)
        begin
            if (out_free)
            begin
                m_valid_next = 1'b1;
                out_next     = res;
                state_next   = ST_IDLE;
            end
            else
            begin
                pend_next  = res;
                state_next = ST_OUT;
            end
        end

        if (len_wr)
        begin
            head_next = '0;
            load_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            load_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            load_reg    <= load_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y0_reg   <= y0_next;
        prod_reg <= prod_next;
        peak_reg <= peak_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_reg.peak_level, out_reg.audio_out};
    assign m_tuser  = out_reg.result_kind;

    `PSS_ASSERT_NOW(a_head_in_line, 1'b1, LW'(head_reg) < line_len, "head beyond line length")
    `PSS_ASSERT_NOW(a_load_in_line, 1'b1, load_reg <= line_len, "load position past line")
    `PSS_ASSERT_NOW(a_out_pending, state_reg == ST_OUT, m_valid_reg, "held result without busy output")

endmodule
